FILE: hw/rtl/bspf_pkg.sv
// Shared types, constants and the arctangent table of the bearing sector filter.
package bspf_pkg;

  // Fixed item and register widths
  localparam int unsigned COORD_W        = 32;
  localparam int unsigned DIFF_W         = COORD_W + 1;
  localparam int unsigned VEC_W          = COORD_W + 4;   // headroom for CORDIC gain
  localparam int unsigned ANGLE_W        = 16;
  localparam int unsigned TDATA_W        = 5 * COORD_W;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned ATAN_TAB_LEN   = 24;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam logic [ANGLE_W-1:0] QUARTER_TURN   = 16'h4000;
  localparam logic [ANGLE_W-1:0] HALF_TURN      = 16'h8000;
  localparam logic [ANGLE_W-1:0] HALF_WIDTH_RST = 16'h2000;   // 45 degrees

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 2'd0,
    REG_CENTER_Y   = 2'd1,
    REG_HEADING    = 2'd2,
    REG_HALF_WIDTH = 2'd3
  } cfg_reg_t;

  // Fields carried unchanged from input to output
  typedef struct packed {
    logic        last;
    logic [COORD_W-1:0] image_v;
    logic [COORD_W-1:0] image_u;
    logic [COORD_W-1:0] world_z;
    logic [COORD_W-1:0] world_y;
    logic [COORD_W-1:0] world_x;
  } pass_t;

  // CORDIC working vector
  typedef struct packed {
    logic               zero;   // offset was (0,0)
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic [ANGLE_W-1:0] z;
  } vec_t;

  // atan(2^-i) in binary angle units, rounded to nearest
  function automatic logic [ANGLE_W-1:0] atan_bam(input int i);
    logic [ANGLE_W-1:0] r;
    case (i)
      0:  r = 16'd8192;
      1:  r = 16'd4836;
      2:  r = 16'd2555;
      3:  r = 16'd1297;
      4:  r = 16'd651;
      5:  r = 16'd326;
      6:  r = 16'd163;
      7:  r = 16'd81;
      8:  r = 16'd41;
      9:  r = 16'd20;
      10: r = 16'd10;
      11: r = 16'd5;
      12: r = 16'd3;
      13: r = 16'd1;
      14: r = 16'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/bearing_sector_point_filter.sv
// Top level of the bearing sector point filter.
// Each match pair is passed on unchanged, flagged in m_tuser (keep) when the bearing of
// (world_x - center_x, world_y - center_y) lies strictly within half_width binary angle
// units of heading plus a quarter turn (65536 units per full turn, 0 along +x). The
// bearing comes from a vectoring CORDIC with one iteration per pipeline stage, so the
// block takes one item every cycle unless the output stalls; items pass the offset, fold,
// CORDIC and sector test registers in order. Every stage stalls on its own, so bubbles
// are squeezed out while the output waits. A zero offset gives bearing 0. Configuration
// must be written only while no item is in flight; the block does not enforce this.
module bearing_sector_point_filter
  import bspf_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input items
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [TDATA_W-1:0]   s_tdata,   // world_x, world_y, world_z, image_u, image_v
  input  logic                 s_tlast,   // last_point
  // Result items
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TDATA_W-1:0]   m_tdata,   // out_world_x, out_world_y, out_world_z,
                                          // out_image_u, out_image_v
  output logic                 m_tlast,   // last_out
  output logic                 m_tuser,   // keep
  // Configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  // Configuration registers
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic [ANGLE_W-1:0]        heading;
  logic [ANGLE_W-1:0]        half_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x   <= '0;
      center_y   <= '0;
      heading    <= '0;
      half_width <= HALF_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:   center_x   <= cfg_data;
        REG_CENTER_Y:   center_y   <= cfg_data;
        REG_HEADING:    heading    <= cfg_data[ANGLE_W-1:0];
        REG_HALF_WIDTH: half_width <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshake wiring
  logic  diff_valid, diff_ready;
  logic  rot_valid, rot_ready;
  logic  cor_valid, cor_ready;
  vec_t  cor_vec;
  pass_t cor_pass;

  // Stage 1: offsets from the center
  logic signed [DIFF_W-1:0] dx, dy;
  pass_t                    diff_pass;
  pass_t                    in_pass;

  assign in_pass.world_x = s_tdata[0*COORD_W +: COORD_W];
  assign in_pass.world_y = s_tdata[1*COORD_W +: COORD_W];
  assign in_pass.world_z = s_tdata[2*COORD_W +: COORD_W];
  assign in_pass.image_u = s_tdata[3*COORD_W +: COORD_W];
  assign in_pass.image_v = s_tdata[4*COORD_W +: COORD_W];
  assign in_pass.last    = s_tlast;

  assign s_tready = !diff_valid || diff_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
    end else if (s_tready) begin
      diff_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      dx        <= DIFF_W'(signed'(in_pass.world_x)) - DIFF_W'(center_x);
      dy        <= DIFF_W'(signed'(in_pass.world_y)) - DIFF_W'(center_y);
      diff_pass <= in_pass;
    end
  end

  // Stage 2: fold the left half plane into the right by a half turn
  vec_t  rot_vec, rot_next;
  pass_t rot_pass;

  always_comb begin
    rot_next.zero = (dx == '0) && (dy == '0);
    if (dx < 0) begin
      rot_next.x = -VEC_W'(dx);
      rot_next.y = -VEC_W'(dy);
      rot_next.z = HALF_TURN;
    end else begin
      rot_next.x = VEC_W'(dx);
      rot_next.y = VEC_W'(dy);
      rot_next.z = '0;
    end
  end

  assign diff_ready = !rot_valid || rot_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_valid <= 1'b0;
    end else if (diff_ready) begin
      rot_valid <= diff_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (diff_ready && diff_valid) begin
      rot_vec  <= rot_next;
      rot_pass <= diff_pass;
    end
  end

  // CORDIC iterations
  bspf_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_vec    (rot_vec),
    .in_pass   (rot_pass),
    .out_valid (cor_valid),
    .out_ready (cor_ready),
    .out_vec   (cor_vec),
    .out_pass  (cor_pass)
  );

  // Final stage: sector test into the output register
  logic [ANGLE_W-1:0] bearing, target, delta, mag;
  logic               keep_next;
  pass_t              out_pass;
  logic               keep;

  always_comb begin
    bearing   = cor_vec.zero ? '0 : cor_vec.z;
    target    = heading + QUARTER_TURN;
    delta     = bearing - target;
    mag       = delta[ANGLE_W-1] ? ANGLE_W'(-delta) : delta;
    keep_next = mag < half_width;
  end

  assign cor_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cor_ready) begin
      m_tvalid <= cor_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cor_ready && cor_valid) begin
      out_pass <= cor_pass;
      keep     <= keep_next;
    end
  end

  assign m_tdata = {out_pass.image_v, out_pass.image_u, out_pass.world_z,
                    out_pass.world_y, out_pass.world_x};
  assign m_tlast = out_pass.last;
  assign m_tuser = keep;

endmodule

FILE: hw/rtl/bspf_cordic.sv
// Vectoring CORDIC pipeline: one iteration per register stage, per-stage stall.
module bspf_cordic
  import bspf_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  vec_t  in_vec,
  input  pass_t in_pass,
  output logic  out_valid,
  input  logic  out_ready,
  output vec_t  out_vec,
  output pass_t out_pass
);

  // Index k holds the result of iteration k; the last index is the output
  vec_t                    vec_q   [CORDIC_STEPS];
  pass_t                   pass_q  [CORDIC_STEPS];
  logic [CORDIC_STEPS-1:0] valid_q;
  wire  [CORDIC_STEPS:0]   ready;

  assign in_ready = ready[0];

  assign ready[CORDIC_STEPS] = out_ready;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;
    vec_t                    nxt;
    vec_t                    cur_vec;
    pass_t                   cur_pass;
    logic                    cur_valid;

    // Stage input: the block input or the previous iteration
    if (k == 0) begin : g_head
      assign cur_vec   = in_vec;
      assign cur_pass  = in_pass;
      assign cur_valid = in_valid;
    end else begin : g_body
      assign cur_vec   = vec_q[k-1];
      assign cur_pass  = pass_q[k-1];
      assign cur_valid = valid_q[k-1];
    end

    // A stage takes new data when empty or when its content moves on
    assign ready[k] = !valid_q[k] || ready[k+1];

    // Micro-rotation toward the x axis
    always_comb begin
      xs       = cur_vec.x >>> k;
      ys       = cur_vec.y >>> k;
      nxt.zero = cur_vec.zero;
      if (cur_vec.y > 0) begin
        nxt.x = cur_vec.x + ys;
        nxt.y = cur_vec.y - xs;
        nxt.z = cur_vec.z + atan_bam(k);
      end else begin
        nxt.x = cur_vec.x - ys;
        nxt.y = cur_vec.y + xs;
        nxt.z = cur_vec.z - atan_bam(k);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else if (ready[k]) begin
        valid_q[k] <= cur_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (ready[k] && cur_valid) begin
        vec_q[k]  <= nxt;
        pass_q[k] <= cur_pass;
      end
    end
  end

  assign out_valid = valid_q[CORDIC_STEPS-1];
  assign out_vec   = vec_q[CORDIC_STEPS-1];
  assign out_pass  = pass_q[CORDIC_STEPS-1];

endmodule
